@@ rtl/tile_grid_obstacle_edge_finder_defines.svh @@
// Assertion macros for the tile grid edge finder RTL.
// Included by the top level; no other dependencies.
`ifndef TILE_GRID_OBSTACLE_EDGE_FINDER_DEFINES_SVH
`define TILE_GRID_OBSTACLE_EDGE_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define TG_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TG_ASSERT_NEXT(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define TG_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define TG_ASSERT_NEXT(label, clk, rstn, a, b, msg)
`endif
`endif

@@ rtl/tgef_pkg.sv @@
// Package for the tile grid edge finder: constants, types and command structs.
// No dependencies.
`default_nettype none
package tgef_pkg;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int TILE_SHIFT_DEF = 5;
    localparam int MAX_SPAN_DEF   = 8;

    localparam logic [1:0] FUNC_WR_TYPE = 2'd0;
    localparam logic [1:0] FUNC_WR_EXPL = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_QUERY   = 2'd3;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WALL_CODE  = 2'd2;
    localparam logic [1:0] REG_VOID_CODE  = 2'd3;

    // Neighbour read order for one window tile.
    localparam logic [2:0] NB_SELF  = 3'd0;
    localparam logic [2:0] NB_UP    = 3'd1;
    localparam logic [2:0] NB_DOWN  = 3'd2;
    localparam logic [2:0] NB_LEFT  = 3'd3;
    localparam logic [2:0] NB_RIGHT = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_READ_OUT, ST_SETUP, ST_ISSUE,
        ST_COLLECT, ST_EMIT, ST_NEXT, ST_EMPTY
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic latch_in;
        logic issue_rd;
        logic [2:0] nb_sel;
        logic rd_self;
        logic capture;
        logic setup_win;
        logic step_win;
        logic load_read_out;
        logic load_hit_out;
        logic load_empty_out;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic win_empty;
        logic win_last;
        logic hit;
        logic hit_pending;
    } stat_t;
endpackage
`default_nettype wire

@@ rtl/tile_grid_obstacle_edge_finder.sv @@
// Top level of the tile grid edge finder: controller plus datapath.
// Depends on tgef_pkg, tgef_ctrl, tgef_datapath and the assertion header.
//
//  channel  | ports                       | beat
//  ---------+-----------------------------+--------------------------------
//  input    | s_valid/s_ready, s_*        | one command
//  result   | m_valid/m_ready, m_*        | one read value or one hit tile
//  config   | cfg_wr_en, cfg_index, ...   | one register write
//
// A query reads the store five times per window tile: the tile itself and
// its up, down, left and right neighbours.
// After reset the store is cleared by a sweep over every address; no beat
// is accepted meanwhile.
// A stalled result beat holds the walk until it is taken.
`default_nettype none
`include "tile_grid_obstacle_edge_finder_defines.svh"
module tile_grid_obstacle_edge_finder #(
    parameter int MAX_WIDTH  = tgef_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgef_pkg::MAX_HEIGHT_DEF,
    parameter int TILE_SHIFT = tgef_pkg::TILE_SHIFT_DEF,
    parameter int MAX_SPAN   = tgef_pkg::MAX_SPAN_DEF
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  cfg_wr_en,
    input  wire  [1:0] cfg_index,
    input  wire  [6:0] cfg_data,
    input  wire  s_valid,
    output logic s_ready,
    input  wire  [1:0] s_func,
    input  wire  signed [7:0] s_cell_x,
    input  wire  signed [7:0] s_cell_y,
    input  wire  [3:0] s_new_type,
    input  wire  s_new_explored,
    input  wire  signed [15:0] s_center_x,
    input  wire  signed [15:0] s_center_y,
    input  wire  [7:0] s_radius,
    output logic m_valid,
    input  wire  m_ready,
    output logic [3:0] m_read_type,
    output logic m_read_explored,
    output logic [5:0] m_hit_x,
    output logic [5:0] m_hit_y,
    output logic [3:0] m_edge_mask,
    output logic m_found,
    output logic m_last
);
    tgef_pkg::cmd_t cmd;
    tgef_pkg::stat_t stat;

    tgef_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    tgef_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .TILE_SHIFT(TILE_SHIFT), .MAX_SPAN(MAX_SPAN)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_func(s_func), .s_cell_x(s_cell_x), .s_cell_y(s_cell_y),
        .s_new_type(s_new_type), .s_new_explored(s_new_explored),
        .s_center_x(s_center_x), .s_center_y(s_center_y), .s_radius(s_radius),
        .cmd(cmd), .stat(stat), .m_read_type(m_read_type),
        .m_read_explored(m_read_explored), .m_hit_x(m_hit_x), .m_hit_y(m_hit_y),
        .m_edge_mask(m_edge_mask), .m_found(m_found), .m_last(m_last)
    );

    `TG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit_x) && $stable(m_last), "result beat changed while stalled")
    `TG_ASSERT_IMPL(a_found_nonzero, aclk, aresetn, (m_valid && m_found) |-> (m_edge_mask != 4'd0), "hit beat without an exposed side")
    `TG_ASSERT_IMPL(a_busy_no_accept, aclk, aresetn, (s_ready && cmd.issue_rd) |-> 1'b0, "input taken while a walk reads the store")
endmodule
`default_nettype wire

@@ rtl/tgef_ctrl.sv @@
// Controller state machine for the tile grid edge finder.
// Depends on tgef_pkg.
`default_nettype none
module tgef_ctrl (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_valid,
    output logic s_ready,
    input  wire  [1:0] s_func,
    output logic m_valid,
    input  wire  m_ready,
    input  wire  tgef_pkg::stat_t stat,
    output tgef_pkg::cmd_t cmd
);
    tgef_pkg::state_t state_reg, state_next;
    logic [2:0] nb_reg, nb_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tgef_pkg::ST_CLEAR;
            nb_reg <= tgef_pkg::NB_SELF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nb_reg <= nb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        nb_next = nb_reg;
        m_valid_next = m_valid_reg;
        cmd = '0;
        s_ready = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            tgef_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = tgef_pkg::ST_IDLE;
                end
            end
            tgef_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    priority case (s_func)
                        tgef_pkg::FUNC_READ: state_next = tgef_pkg::ST_READ;
                        tgef_pkg::FUNC_QUERY: state_next = tgef_pkg::ST_SETUP;
                        default: state_next = tgef_pkg::ST_IDLE;
                    endcase
                end
            end
            tgef_pkg::ST_READ: begin
                cmd.issue_rd = 1'b1;
                cmd.rd_self = 1'b1;
                cmd.nb_sel = tgef_pkg::NB_SELF;
                state_next = tgef_pkg::ST_READ_OUT;
            end
            tgef_pkg::ST_READ_OUT: begin
                if (!m_valid_next) begin
                    cmd.load_read_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = tgef_pkg::ST_IDLE;
                end
            end
            tgef_pkg::ST_SETUP: begin
                cmd.setup_win = 1'b1;
                nb_next = tgef_pkg::NB_SELF;
                state_next = tgef_pkg::ST_ISSUE;
            end
            tgef_pkg::ST_ISSUE: begin
                if (stat.win_empty) begin
                    state_next = tgef_pkg::ST_EMPTY;
                end else begin
                    cmd.issue_rd = 1'b1;
                    cmd.nb_sel = nb_reg;
                    state_next = tgef_pkg::ST_COLLECT;
                end
            end
            tgef_pkg::ST_COLLECT: begin
                cmd.capture = 1'b1;
                cmd.nb_sel = nb_reg;
                if (nb_reg == tgef_pkg::NB_RIGHT) begin
                    nb_next = tgef_pkg::NB_SELF;
                    state_next = tgef_pkg::ST_EMIT;
                end else begin
                    nb_next = nb_reg + 3'd1;
                    state_next = tgef_pkg::ST_ISSUE;
                end
            end
            tgef_pkg::ST_EMIT: begin
                // A held hit goes out when the next hit or the window end is known.
                if (stat.hit && stat.hit_pending) begin
                    if (!m_valid_next) begin
                        cmd.load_hit_out = 1'b1;
                        m_valid_next = 1'b1;
                        state_next = tgef_pkg::ST_NEXT;
                    end
                end else begin
                    state_next = tgef_pkg::ST_NEXT;
                end
            end
            tgef_pkg::ST_NEXT: begin
                if (stat.win_last) begin
                    if (stat.hit_pending || stat.hit) begin
                        if (!m_valid_next) begin
                            cmd.load_hit_out = 1'b1;
                            cmd.step_win = 1'b1;
                            m_valid_next = 1'b1;
                            state_next = tgef_pkg::ST_IDLE;
                        end
                    end else begin
                        state_next = tgef_pkg::ST_EMPTY;
                    end
                end else begin
                    cmd.step_win = 1'b1;
                    state_next = tgef_pkg::ST_ISSUE;
                end
            end
            tgef_pkg::ST_EMPTY: begin
                if (!m_valid_next) begin
                    cmd.load_empty_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = tgef_pkg::ST_IDLE;
                end
            end
            default: state_next = tgef_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/tgef_datapath.sv @@
// Datapath for the tile grid edge finder: tile store, window walker and result register.
// Depends on tgef_pkg.
`default_nettype none
module tgef_datapath #(
    parameter int MAX_WIDTH  = tgef_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tgef_pkg::MAX_HEIGHT_DEF,
    parameter int TILE_SHIFT = tgef_pkg::TILE_SHIFT_DEF,
    parameter int MAX_SPAN   = tgef_pkg::MAX_SPAN_DEF
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  cfg_wr_en,
    input  wire  [1:0] cfg_index,
    input  wire  [6:0] cfg_data,
    input  wire  [1:0] s_func,
    input  wire  signed [7:0] s_cell_x,
    input  wire  signed [7:0] s_cell_y,
    input  wire  [3:0] s_new_type,
    input  wire  s_new_explored,
    input  wire  signed [15:0] s_center_x,
    input  wire  signed [15:0] s_center_y,
    input  wire  [7:0] s_radius,
    input  wire  tgef_pkg::cmd_t cmd,
    output tgef_pkg::stat_t stat,
    output logic [3:0] m_read_type,
    output logic m_read_explored,
    output logic [5:0] m_hit_x,
    output logic [5:0] m_hit_y,
    output logic [3:0] m_edge_mask,
    output logic m_found,
    output logic m_last
);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int RCAP = ((MAX_SPAN - 1) << TILE_SHIFT) / 2;
    localparam int CW = 20;

    logic [6:0] map_w_reg, map_h_reg;
    logic [3:0] wall_reg, void_reg;
    logic [8:0] eff_w, eff_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_w_reg <= 7'd64;
            map_h_reg <= 7'd64;
            wall_reg <= 4'd1;
            void_reg <= 4'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tgef_pkg::REG_MAP_WIDTH: map_w_reg <= cfg_data;
                tgef_pkg::REG_MAP_HEIGHT: map_h_reg <= cfg_data;
                tgef_pkg::REG_WALL_CODE: wall_reg <= cfg_data[3:0];
                tgef_pkg::REG_VOID_CODE: void_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign eff_w = ({2'b00, map_w_reg} < 9'(MAX_WIDTH)) ? {2'b00, map_w_reg} : 9'(MAX_WIDTH);
    assign eff_h = ({2'b00, map_h_reg} < 9'(MAX_HEIGHT)) ? {2'b00, map_h_reg} : 9'(MAX_HEIGHT);

    // Latched input beat.
    logic signed [9:0] cx_reg, cy_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic [7:0] rad_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cx_reg <= 10'(s_cell_x);
            cy_reg <= 10'(s_cell_y);
            px_reg <= CW'(s_center_x);
            py_reg <= CW'(s_center_y);
            rad_reg <= s_radius;
        end
    end

    logic in_write;
    logic signed [9:0] icx, icy;
    assign icx = 10'(s_cell_x);
    assign icy = 10'(s_cell_y);
    assign in_write = (icx >= 0) && (icy >= 0) && (icx < $signed({1'b0, eff_w}))
                      && (icy < $signed({1'b0, eff_h}));

    // Window registers.
    logic signed [CW-1:0] rr, lo_x, hi_x, lo_y, hi_y;
    logic signed [9:0] x0_reg, x1_reg, y0_reg, x_reg, y_reg, y1_reg;
    logic signed [9:0] wx0, wx1, wy0, wy1;

    assign rr = ({1'b0, rad_reg} > 9'(RCAP)) ? CW'(RCAP) : CW'(rad_reg);
    assign lo_x = (px_reg - rr) >>> TILE_SHIFT;
    assign hi_x = (px_reg + rr) >>> TILE_SHIFT;
    assign lo_y = (py_reg - rr) >>> TILE_SHIFT;
    assign hi_y = (py_reg + rr) >>> TILE_SHIFT;

    always_comb begin
        wx0 = (lo_x < 0) ? 10'sd0 : ((lo_x > 511) ? 10'sd511 : 10'(lo_x));
        wy0 = (lo_y < 0) ? 10'sd0 : ((lo_y > 511) ? 10'sd511 : 10'(lo_y));
        wx1 = (hi_x > $signed(CW'(eff_w)) - 1) ? 10'($signed({1'b0, eff_w}) - 10'sd1)
              : ((hi_x < -1) ? -10'sd1 : 10'(hi_x));
        wy1 = (hi_y > $signed(CW'(eff_h)) - 1) ? 10'($signed({1'b0, eff_h}) - 10'sd1)
              : ((hi_y < -1) ? -10'sd1 : 10'(hi_y));
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup_win) begin
            x0_reg <= wx0;
            x1_reg <= wx1;
            y0_reg <= wy0;
            y1_reg <= wy1;
            x_reg <= wx0;
            y_reg <= wy0;
        end else if (cmd.step_win) begin
            if (x_reg == x1_reg) begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 10'sd1;
            end else begin
                x_reg <= x_reg + 10'sd1;
            end
        end
    end

    assign stat.win_empty = (x0_reg > x1_reg) || (y0_reg > y1_reg);
    assign stat.win_last = (x_reg == x1_reg) && (y_reg == y1_reg);

    // Neighbour coordinate and read address.
    logic signed [9:0] qx, qy;
    logic q_in;
    always_comb begin
        qx = x_reg;
        qy = y_reg;
        if (cmd.rd_self) begin
            qx = cx_reg;
            qy = cy_reg;
        end else begin
            unique case (cmd.nb_sel)
                tgef_pkg::NB_UP: qy = y_reg - 10'sd1;
                tgef_pkg::NB_DOWN: qy = y_reg + 10'sd1;
                tgef_pkg::NB_LEFT: qx = x_reg - 10'sd1;
                tgef_pkg::NB_RIGHT: qx = x_reg + 10'sd1;
                default: ;
            endcase
        end
        q_in = (qx >= 0) && (qy >= 0) && (qx < $signed({1'b0, eff_w}))
               && (qy < $signed({1'b0, eff_h}));
    end

    // Tile store, cleared by a sweep after reset.
    logic [3:0] type_mem [DEPTH];
    logic expl_mem [DEPTH];
    logic [AW:0] clr_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [3:0] rd_type_reg;
    logic rd_expl_reg;
    logic rd_in_reg;

    assign stat.clear_done = clr_reg[AW];
    assign wr_addr = {icy[YW-1:0], icx[XW-1:0]};
    assign rd_addr = {qy[YW-1:0], qx[XW-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step && !clr_reg[AW]) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    logic write_hit;
    assign write_hit = cmd.latch_in && in_write
                       && ((s_func == tgef_pkg::FUNC_WR_TYPE) || (s_func == tgef_pkg::FUNC_WR_EXPL));

    always_ff @(posedge aclk) begin
        if (cmd.clear_step && !clr_reg[AW]) begin
            type_mem[clr_reg[AW-1:0]] <= '0;
            expl_mem[clr_reg[AW-1:0]] <= 1'b0;
        end else if (write_hit) begin
            if (s_func == tgef_pkg::FUNC_WR_TYPE) begin
                type_mem[wr_addr] <= s_new_type;
            end else begin
                expl_mem[wr_addr] <= s_new_explored;
            end
        end
        if (cmd.issue_rd) begin
            rd_type_reg <= type_mem[rd_addr];
            rd_expl_reg <= expl_mem[rd_addr];
            rd_in_reg <= q_in;
        end
    end

    logic [3:0] rtype;
    logic rsolid;
    assign rtype = rd_in_reg ? rd_type_reg : void_reg;
    assign rsolid = (rtype == wall_reg) || (rtype == void_reg);

    // Per-tile capture of self solidity and exposed sides.
    logic self_solid_reg;
    logic [3:0] mask_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            unique case (cmd.nb_sel)
                tgef_pkg::NB_SELF: begin
                    self_solid_reg <= rsolid;
                    mask_reg <= '0;
                end
                tgef_pkg::NB_UP: mask_reg[0] <= (y_reg == 0) || !rsolid;
                tgef_pkg::NB_DOWN:
                    mask_reg[1] <= (y_reg == $signed({1'b0, eff_h}) - 10'sd1) || !rsolid;
                tgef_pkg::NB_LEFT: mask_reg[2] <= (x_reg == 0) || !rsolid;
                tgef_pkg::NB_RIGHT:
                    mask_reg[3] <= (x_reg == $signed({1'b0, eff_w}) - 10'sd1) || !rsolid;
                default: ;
            endcase
        end
    end

    assign stat.hit = self_solid_reg && (mask_reg != 4'd0);

    // One hit is held back so the final hit of a window can carry last.
    logic pend_reg;
    logic [5:0] pend_x, pend_y;
    logic [3:0] pend_m;
    assign stat.hit_pending = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.setup_win) begin
            pend_reg <= 1'b0;
        end else if (cmd.load_hit_out && cmd.step_win) begin
            pend_reg <= 1'b0;
        end else if (cmd.step_win && stat.hit) begin
            pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_win && stat.hit) begin
            pend_x <= 6'(x_reg);
            pend_y <= 6'(y_reg);
            pend_m <= mask_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.load_read_out) begin
            m_read_type <= rtype;
            m_read_explored <= rd_in_reg & rd_expl_reg;
            m_hit_x <= '0;
            m_hit_y <= '0;
            m_edge_mask <= '0;
            m_found <= 1'b0;
            m_last <= 1'b1;
        end else if (cmd.load_hit_out) begin
            m_read_type <= '0;
            m_read_explored <= 1'b0;
            m_found <= 1'b1;
            if (cmd.step_win) begin
                // End of window: the held hit if the current tile missed, else the current.
                m_last <= 1'b1;
                if (stat.hit && pend_reg) begin
                    m_hit_x <= 6'(x_reg);
                    m_hit_y <= 6'(y_reg);
                    m_edge_mask <= mask_reg;
                end else if (stat.hit) begin
                    m_hit_x <= 6'(x_reg);
                    m_hit_y <= 6'(y_reg);
                    m_edge_mask <= mask_reg;
                end else begin
                    m_hit_x <= pend_x;
                    m_hit_y <= pend_y;
                    m_edge_mask <= pend_m;
                end
            end else begin
                m_last <= 1'b0;
                m_hit_x <= pend_x;
                m_hit_y <= pend_y;
                m_edge_mask <= pend_m;
            end
        end else if (cmd.load_empty_out) begin
            m_read_type <= '0;
            m_read_explored <= 1'b0;
            m_hit_x <= '0;
            m_hit_y <= '0;
            m_edge_mask <= '0;
            m_found <= 1'b0;
            m_last <= 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ verif/tb_tile_grid_obstacle_edge_finder.sv @@
// Self-checking testbench for the tile grid edge finder: directed and random commands,
// with a behavioural model of the grid predicting every result beat.
// Depends on tgef_pkg and the tile_grid_obstacle_edge_finder RTL.
`default_nettype none
module tb_tile_grid_obstacle_edge_finder;
    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int SHIFT = 5;
    localparam int SPAN = 8;
    localparam int RADIUS_CAP = ((SPAN - 1) << SHIFT) / 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] func;
        logic signed [7:0] cell_x;
        logic signed [7:0] cell_y;
        logic [3:0] new_type;
        logic new_explored;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [7:0] radius;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0] read_type;
        logic read_explored;
        logic [5:0] hit_x;
        logic [5:0] hit_y;
        logic [3:0] edge_mask;
        logic found;
        logic last;
    } res_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = tgef_pkg::REG_MAP_WIDTH;
    logic [6:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    cmd_beat_t s_beat = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_beat_t m_beat;

    logic [3:0] grid_type [GRID_W*GRID_H];
    logic grid_expl [GRID_W*GRID_H];
    int cfg_w, cfg_h, cfg_wall, cfg_void;

    cmd_beat_t pending_cmds[$];
    res_beat_t expected_beats[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    tile_grid_obstacle_edge_finder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_beat.func), .s_cell_x(s_beat.cell_x), .s_cell_y(s_beat.cell_y),
        .s_new_type(s_beat.new_type), .s_new_explored(s_beat.new_explored),
        .s_center_x(s_beat.center_x), .s_center_y(s_beat.center_y),
        .s_radius(s_beat.radius),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_read_type(m_beat.read_type), .m_read_explored(m_beat.read_explored),
        .m_hit_x(m_beat.hit_x), .m_hit_y(m_beat.hit_y), .m_edge_mask(m_beat.edge_mask),
        .m_found(m_beat.found), .m_last(m_beat.last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void add_expected(input res_beat_t e);
        expected_beats.insert(expected_beats.size(), e);
    endfunction

    function automatic void add_cmd(input cmd_beat_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic int eff_w();
        return cfg_w < GRID_W ? cfg_w : GRID_W;
    endfunction

    function automatic int eff_h();
        return cfg_h < GRID_H ? cfg_h : GRID_H;
    endfunction

    function automatic bit on_map(int x, int y);
        return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    function automatic bit is_solid(int x, int y);
        int t;
        t = on_map(x, y) ? int'(grid_type[y*GRID_W + x]) : cfg_void;
        return t == cfg_wall || t == cfg_void;
    endfunction

    // Arithmetic shift floors negative pixel values as the block does.
    function automatic int tile_of(int v);
        return v >>> SHIFT;
    endfunction

    task automatic predict_edges(input cmd_beat_t c);
        int r, x0, x1, y0, y1, w, h, hits;
        logic [3:0] m;
        res_beat_t e;
        w = eff_w();
        h = eff_h();
        hits = 0;
        r = c.radius > RADIUS_CAP ? RADIUS_CAP : int'(c.radius);
        x0 = tile_of(int'(c.center_x) - r);
        x1 = tile_of(int'(c.center_x) + r);
        y0 = tile_of(int'(c.center_y) - r);
        y1 = tile_of(int'(c.center_y) + r);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > w - 1) x1 = w - 1;
        if (y1 > h - 1) y1 = h - 1;
        for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
                if (is_solid(x, y)) begin
                    m = '0;
                    if (y == 0 || !is_solid(x, y - 1)) m[0] = 1'b1;
                    if (y == h - 1 || !is_solid(x, y + 1)) m[1] = 1'b1;
                    if (x == 0 || !is_solid(x - 1, y)) m[2] = 1'b1;
                    if (x == w - 1 || !is_solid(x + 1, y)) m[3] = 1'b1;
                    if (m != 0 && hits < SPAN*SPAN) begin
                        e = '0;
                        e.hit_x = x[5:0];
                        e.hit_y = y[5:0];
                        e.edge_mask = m;
                        e.found = 1'b1;
                        add_expected(e);
                        hits++;
                    end
                end
            end
        end
        if (hits == 0) begin
            e = '0;
            e.last = 1'b1;
            add_expected(e);
        end else begin
            e = expected_beats.pop_back();
            e.last = 1'b1;
            add_expected(e);
        end
    endtask

    task automatic predict_command(input cmd_beat_t c);
        int x, y;
        res_beat_t e;
        x = c.cell_x;
        y = c.cell_y;
        case (c.func)
            tgef_pkg::FUNC_WR_TYPE: if (on_map(x, y)) grid_type[y*GRID_W + x] = c.new_type;
            tgef_pkg::FUNC_WR_EXPL: if (on_map(x, y)) grid_expl[y*GRID_W + x] = c.new_explored;
            tgef_pkg::FUNC_READ: begin
                e = '0;
                e.last = 1'b1;
                e.read_type = cfg_void[3:0];
                if (on_map(x, y)) begin
                    e.read_type = grid_type[y*GRID_W + x];
                    e.read_explored = grid_expl[y*GRID_W + x];
                end
                add_expected(e);
            end
            default: predict_edges(c);
        endcase
    endtask

    // Driver: pops the queue; valid holds until the beat is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_command(s_beat);
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_beat <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %p", m_beat);
            end else begin
                res_beat_t e;
                e = expected_beats.pop_front();
                if (e !== m_beat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, m_beat);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (timed_out) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic cmd_beat_t rand_cmd();
        cmd_beat_t c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[62:0];
        return c;
    endfunction

    function automatic cmd_beat_t make_cmd(logic [1:0] f, int x, int y, int t);
        cmd_beat_t c;
        c = rand_cmd();
        c.func = f;
        c.cell_x = x[7:0];
        c.cell_y = y[7:0];
        c.new_type = t[3:0];
        c.new_explored = t[0];
        return c;
    endfunction

    function automatic cmd_beat_t make_query(int px, int py, int r);
        cmd_beat_t c;
        c = rand_cmd();
        c.func = tgef_pkg::FUNC_QUERY;
        c.center_x = px[15:0];
        c.center_y = py[15:0];
        c.radius = r[7:0];
        return c;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[6:0];
        case (idx)
            tgef_pkg::REG_MAP_WIDTH: cfg_w = value;
            tgef_pkg::REG_MAP_HEIGHT: cfg_h = value;
            tgef_pkg::REG_WALL_CODE: cfg_wall = value;
            default: cfg_void = value;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        cmd_beat_t c;
        int x, y;
        for (int i = 0; i < count; i++) begin
            x = $urandom_range(11);
            y = $urandom_range(11);
            case ($urandom_range(9))
                0, 1, 2, 3: c = make_cmd(tgef_pkg::FUNC_WR_TYPE, x, y, $urandom_range(3));
                4: c = make_cmd(tgef_pkg::FUNC_WR_EXPL, x, y, $urandom);
                5: c = make_cmd(tgef_pkg::FUNC_READ, x, y, 0);
                6: c = rand_cmd();
                default: c = make_query($urandom_range(400) - 20, $urandom_range(400) - 20,
                                        $urandom_range(255));
            endcase
            add_cmd(c);
        end
    endtask

    initial begin
        for (int i = 0; i < GRID_W*GRID_H; i++) begin
            grid_type[i] = '0;
            grid_expl[i] = 1'b0;
        end
        cfg_w = 64;
        cfg_h = 64;
        cfg_wall = 1;
        cfg_void = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(tgef_pkg::REG_WALL_CODE, 15);
        write_reg(tgef_pkg::REG_VOID_CODE, 14);
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, 0, 0, 15));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, 63, 63, 15));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, 64, 0, 3));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, -1, 5, 3));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, 1, 0, 14));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_EXPL, 63, 63, 1));
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_EXPL, -128, 127, 1));
        add_cmd(make_cmd(tgef_pkg::FUNC_READ, 0, 0, 0));
        add_cmd(make_cmd(tgef_pkg::FUNC_READ, 63, 63, 0));
        add_cmd(make_cmd(tgef_pkg::FUNC_READ, 127, -128, 0));
        add_cmd(make_query(0, 0, 0));
        add_cmd(make_query(0, 0, 255));
        add_cmd(make_query(2047, 2047, 255));
        add_cmd(make_query(-32768, -32768, 255));
        add_cmd(make_query(32767, 32767, 255));
        add_cmd(make_query(1000, 1000, 40));
        add_cmd(make_query(-5, 100, 3));
        drain();

        write_reg(tgef_pkg::REG_MAP_WIDTH, 127);
        write_reg(tgef_pkg::REG_MAP_HEIGHT, 0);
        add_cmd(make_cmd(tgef_pkg::FUNC_WR_TYPE, 2, 2, 5));
        add_cmd(make_cmd(tgef_pkg::FUNC_READ, 0, 0, 0));
        add_cmd(make_query(50, 50, 100));
        drain();

        write_reg(tgef_pkg::REG_MAP_WIDTH, 0);
        write_reg(tgef_pkg::REG_MAP_HEIGHT, 127);
        add_cmd(make_query(50, 50, 100));
        drain();

        write_reg(tgef_pkg::REG_MAP_WIDTH, 12);
        write_reg(tgef_pkg::REG_MAP_HEIGHT, 10);
        write_reg(tgef_pkg::REG_WALL_CODE, 1);
        write_reg(tgef_pkg::REG_VOID_CODE, 0);
        send_idle_pct = 25;
        recv_idle_pct = 66;
        random_phase(44);
        drain();

        write_reg(tgef_pkg::REG_MAP_WIDTH, 1);
        write_reg(tgef_pkg::REG_MAP_HEIGHT, 64);
        write_reg(tgef_pkg::REG_WALL_CODE, 2);
        write_reg(tgef_pkg::REG_VOID_CODE, 2);
        send_idle_pct = 66;
        recv_idle_pct = 25;
        random_phase(44);
        drain();

        write_reg(tgef_pkg::REG_MAP_WIDTH, 64);
        write_reg(tgef_pkg::REG_MAP_HEIGHT, 12);
        write_reg(tgef_pkg::REG_WALL_CODE, 3);
        write_reg(tgef_pkg::REG_VOID_CODE, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(44);
        drain();

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
